// File: rtl/hs_pkg.sv
// Shared types, constants and the heap ordering function for the heap sorter.
// No dependencies; every other file of the block imports this package.
package hs_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	// Control half of the element memory port.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// True when a must sit above b in the heap: larger in a max heap,
	// smaller in a min heap.
	function automatic logic outranks(
		input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b,
		input logic              min_heap
	);
		logic a_lt_b;
		logic b_lt_a;
		a_lt_b = $signed(a) < $signed(b);
		b_lt_a = $signed(b) < $signed(a);
		return min_heap ? a_lt_b : b_lt_a;
	endfunction

endpackage

// File: rtl/hs_mem.sv
// Element store of the heap sorter: one write port, one read port with a
// registered read. Depends on hs_pkg.
module hs_mem
	import hs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                        clk,
	input  mem_ctl_t                    ctl,
	input  logic [$clog2(CAPACITY)-1:0] waddr,
	input  logic [DATA_W-1:0]           wdata,
	input  logic [$clog2(CAPACITY)-1:0] raddr,
	output logic [DATA_W-1:0]           rdata
);

	logic [DATA_W-1:0] store_q [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			store_q[waddr] <= wdata;
		end
	end

	// The read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/hs_seq.sv
// Heap sort sequencer: builds the heap and extracts it in place through the
// element memory, at most one access per cycle. Depends on hs_pkg.
module hs_seq
	import hs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(CAPACITY+1)-1:0] n,
	input  logic                          min_heap,
	output logic                          done,
	output mem_ctl_t                      ctl,
	output logic [$clog2(CAPACITY)-1:0]   waddr,
	output logic [DATA_W-1:0]             wdata,
	output logic [$clog2(CAPACITY)-1:0]   raddr,
	input  logic [DATA_W-1:0]             rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = AW + 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_BLD  = 4'd1;
	localparam logic [3:0] S_TOPW = 4'd2;
	localparam logic [3:0] S_KID  = 4'd3;
	localparam logic [3:0] S_KID2 = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_RET  = 4'd6;
	localparam logic [3:0] S_EXT  = 4'd7;
	localparam logic [3:0] S_EXR1 = 4'd8;
	localparam logic [3:0] S_EXR2 = 4'd9;

	logic [3:0]        state_q;
	logic              build_q;
	logic              two_q;
	logic              min_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     len_q;
	logic [AW-1:0]     node_q;
	logic [DATA_W-1:0] nv_q;
	logic [DATA_W-1:0] a_q;

	logic [CW-1:0]     i_m1;
	logic [KW-1:0]     kid1;
	logic [KW-1:0]     kid2;
	logic [KW-1:0]     lenx;
	logic              has_kid;
	logic              pick_b;
	logic [DATA_W-1:0] best;
	logic [AW-1:0]     best_idx;
	logic              promote;

	assign i_m1    = i_q - CW'(1);
	assign kid1    = {1'b0, node_q, 1'b1};
	assign kid2    = kid1 + KW'(1);
	assign lenx    = KW'(len_q);
	assign has_kid = kid1 < lenx;

	// The moving element stays in nv_q; the better child is pulled up into
	// the hole until it no longer outranks the moving element.
	assign pick_b   = two_q && outranks(rdata, a_q, min_q);
	assign best     = pick_b ? rdata : a_q;
	assign best_idx = pick_b ? kid2[AW-1:0] : kid1[AW-1:0];
	assign promote  = outranks(best, nv_q, min_q);

	assign done = (state_q == S_EXT) && (i_q <= CW'(1));

	always_comb begin
		ctl   = '0;
		waddr = node_q;
		wdata = nv_q;
		raddr = kid1[AW-1:0];
		case (state_q)
			S_BLD: begin
				if (i_q != '0) begin
					ctl.rd_en = 1'b1;
					raddr     = i_m1[AW-1:0];
				end
			end
			S_KID: begin
				if (has_kid) begin
					ctl.rd_en = 1'b1;
				end else begin
					ctl.wr_en = 1'b1;
				end
			end
			S_KID2: begin
				if (kid2 < lenx) begin
					ctl.rd_en = 1'b1;
					raddr     = kid2[AW-1:0];
				end
			end
			S_CMP: begin
				ctl.wr_en = 1'b1;
				if (promote) begin
					wdata = best;
				end
			end
			S_EXT: begin
				if (i_q > CW'(1)) begin
					ctl.rd_en = 1'b1;
					raddr     = '0;
				end
			end
			S_EXR1: begin
				ctl.rd_en = 1'b1;
				raddr     = i_m1[AW-1:0];
			end
			S_EXR2: begin
				ctl.wr_en = 1'b1;
				waddr     = i_m1[AW-1:0];
				wdata     = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			build_q <= 1'b0;
			two_q   <= 1'b0;
			min_q   <= 1'b0;
			i_q     <= '0;
			len_q   <= '0;
			node_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q     <= n >> 1;
						len_q   <= n;
						min_q   <= min_heap;
						build_q <= 1'b1;
						state_q <= S_BLD;
					end
				end
				S_BLD: begin
					if (i_q == '0) begin
						i_q     <= len_q;
						build_q <= 1'b0;
						state_q <= S_EXT;
					end else begin
						node_q  <= i_m1[AW-1:0];
						state_q <= S_TOPW;
					end
				end
				S_TOPW: begin
					state_q <= S_KID;
				end
				S_KID: begin
					state_q <= has_kid ? S_KID2 : S_RET;
				end
				S_KID2: begin
					two_q   <= kid2 < lenx;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (promote) begin
						node_q  <= best_idx;
						state_q <= S_KID;
					end else begin
						state_q <= S_RET;
					end
				end
				S_RET: begin
					i_q     <= i_m1;
					state_q <= build_q ? S_BLD : S_EXT;
				end
				S_EXT: begin
					state_q <= (i_q > CW'(1)) ? S_EXR1 : S_IDLE;
				end
				S_EXR1: begin
					state_q <= S_EXR2;
				end
				S_EXR2: begin
					node_q  <= '0;
					len_q   <= i_m1;
					state_q <= S_KID;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Element payload registers: loaded from the read data as it arrives.
	always_ff @(posedge clk) begin
		if (state_q == S_TOPW || state_q == S_EXR2) begin
			nv_q <= rdata;
		end
		if (state_q == S_KID2 || state_q == S_EXR1) begin
			a_q <= rdata;
		end
	end

`ifndef SYNTHESIS
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en && ctl.rd_en |-> waddr != raddr)
		else $error("hs_seq: read and write of one entry in one cycle");
	a_node_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_KID |-> CW'(node_q) < len_q)
		else $error("hs_seq: sift node outside the heap");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && state_q == S_IDLE)
		else $error("hs_seq: done not a single pulse");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !start)
		else $error("hs_seq: start while sorting");
`endif

endmodule

// File: rtl/heap_sorter.sv
// Heap sorter top level: batch loading, sort hand-off and result emission.
// Depends on hs_pkg, hs_mem and hs_seq.
//
// Input transactions carry one signed 32-bit value each; a transaction with
// last_item set closes the batch. Up to CAPACITY values are stored, further
// ones are dropped and every result of that batch has overflowed set.
// Loading accepts one transaction per cycle. After the closing transaction
// in_stall stays high while the batch is heap-sorted in the element memory
// and then emitted, sorted_value ascending (descending when the register is
// 1, sampled when the batch closes), with last_result on the final result.
// Each level of a sift-down reads the first child, then the second, then
// compares with write-back (S_KID, S_KID2, S_CMP), as the element memory has
// one read port; each sift also passes setup states and S_RET. The sort work
// grows as n*log2(n). Each result is emitted by a memory read (ST_ERD), then
// an output load (ST_EWT). The output register holds a stalled result
// unchanged; emission waits on it. After the sort finishes, the first result
// is read in ST_ERD and loaded into the output register in ST_EWT.
// Reset clears the count, the overflow flag, the register and the valid
// bit; the element memory itself is not cleared, nor needs to be.
module heap_sorter
	import hs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic                     cfg_write_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     last_result,
	output logic                     overflowed
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_ERD  = 2'd2;
	localparam logic [1:0] ST_EWT  = 2'd3;

	logic [1:0]        state_q;
	logic              desc_q;
	logic              min_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic              start_q;
	logic [AW-1:0]     k_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              in_acc;
	logic              room;
	logic              out_free;
	logic              emit_last;

	mem_ctl_t          seq_ctl;
	logic [AW-1:0]     seq_waddr;
	logic [DATA_W-1:0] seq_wdata;
	logic [AW-1:0]     seq_raddr;
	logic              seq_done;

	mem_ctl_t          mem_ctl;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	assign in_stall  = state_q != ST_LOAD;
	assign in_acc    = in_valid && !in_stall;
	assign room      = count_q < CW'(CAPACITY);
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = (CW'(k_q) + CW'(1)) == count_q;

	// The sequencer owns the memory while sorting; loading and emission
	// use it otherwise.
	always_comb begin
		if (state_q == ST_SORT) begin
			mem_ctl   = seq_ctl;
			mem_waddr = seq_waddr;
			mem_wdata = seq_wdata;
			mem_raddr = seq_raddr;
		end else begin
			mem_ctl.wr_en = in_acc && room;
			mem_ctl.rd_en = state_q == ST_ERD;
			mem_waddr     = count_q[AW-1:0];
			mem_wdata     = value;
			mem_raddr     = k_q;
		end
	end

	hs_mem #(
		.CAPACITY(CAPACITY)
	) u_mem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	hs_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.n       (count_q),
		.min_heap(min_q),
		.done    (seq_done),
		.ctl     (seq_ctl),
		.waddr   (seq_waddr),
		.wdata   (seq_wdata),
		.raddr   (seq_raddr),
		.rdata   (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			desc_q      <= 1'b0;
			min_q       <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			start_q     <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_acc && last_item;
			if (cfg_write_en) begin
				desc_q <= cfg_write_data;
			end
			if (out_valid_q && !out_stall && state_q != ST_EWT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							min_q   <= desc_q;
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (seq_done) begin
						k_q     <= '0;
						state_q <= ST_ERD;
					end
				end
				ST_ERD: begin
					state_q <= ST_EWT;
				end
				ST_EWT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_ERD;
						end
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EWT && out_free) begin
			out_value_q <= mem_rdata;
			out_last_q  <= emit_last;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign last_result  = out_last_q;
	assign overflowed   = out_ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("heap_sorter: element count beyond capacity");
	a_sort_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> count_q != '0)
		else $error("heap_sorter: sort started on an empty batch");
	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EWT && out_free && emit_last |=> count_q == '0 && !ovf_q)
		else $error("heap_sorter: batch state not cleared after last result");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for heap_sorter: batches of signed values are sent,
// and each sorted batch that comes back is checked against a software sort.
// Depends on hs_pkg and the heap_sorter RTL.
`timescale 1ns / 1ps

module testbench;
	import hs_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic signed [DATA_W-1:0] val;
		logic                     last;
	} load_item_t;

	typedef struct {
		logic signed [DATA_W-1:0] val;
		logic                     last;
		logic                     ovf;
	} sorted_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic                     cfg_write_data = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] value = '0;
	logic                     last_item = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last_result;
	logic                     overflowed;

	load_item_t     pending_items[$];
	sorted_result_t sorted_expect[$];

	// Software copy of the batch being loaded and of the order register.
	logic signed [DATA_W-1:0] batch_store [CAPACITY_DEF];
	int                       batch_count = 0;
	bit                       batch_dropped = 1'b0;
	bit                       sort_descending = 1'b0;

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int offered_count = 0;
	int accepted_count = 0;
	int idle_cycles = 0;
	int mismatches = 0;

	heap_sorter #(
		.CAPACITY(CAPACITY_DEF)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sorted_value  (sorted_value),
		.last_result   (last_result),
		.overflowed    (overflowed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stores one accepted value; a closing transaction sorts the batch and
	// queues the whole ordered batch as expected results.
	task automatic load_and_sort(input logic signed [DATA_W-1:0] v, input logic is_last);
		logic signed [DATA_W-1:0] ordered [CAPACITY_DEF];
		logic signed [DATA_W-1:0] key;
		sorted_result_t           r;
		int                       j;
		if (batch_count < CAPACITY_DEF) begin
			batch_store[batch_count] = v;
			batch_count++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (is_last) begin
			for (int i = 0; i < batch_count; i++) begin
				key = batch_store[i];
				j = i;
				while (j > 0 && (sort_descending ? ordered[j-1] < key : ordered[j-1] > key)) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = key;
			end
			for (int i = 0; i < batch_count; i++) begin
				r.val  = ordered[i];
				r.last = (i == batch_count - 1);
				r.ovf  = batch_dropped;
				sorted_expect.push_back(r);
			end
			batch_count = 0;
			batch_dropped = 1'b0;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 15)) - 8;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(input logic signed [DATA_W-1:0] v, input logic is_last);
		load_item_t it;
		it.val = v;
		it.last = is_last;
		pending_items.push_back(it);
	endtask

	task automatic push_batch(input int len);
		for (int i = 0; i < len; i++)
			push_item(random_value(), i == len - 1);
	endtask

	// Extremes, alternating bit patterns and a tie in one batch.
	task automatic push_extremes();
		push_item(32'sh8000_0000, 1'b0);
		push_item(32'sh7fff_ffff, 1'b0);
		push_item(0, 1'b0);
		push_item(-1, 1'b0);
		push_item(1, 1'b0);
		push_item(32'sh5555_5555, 1'b0);
		push_item(32'shaaaa_aaaa, 1'b0);
		push_item(5, 1'b0);
		push_item(5, 1'b1);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || sorted_expect.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_order(input bit desc);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= desc;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		sort_descending = desc;
	endtask

	// Random batches under one idling pattern; a nonzero big_len sends one batch of big_len values instead.
	task automatic run_phase(input int in_pct, input int out_pct, input bit desc,
	                         input int big_len);
		int total;
		write_order(desc);
		in_idle_pct = in_pct;
		out_stall_pct = out_pct;
		total = 0;
		if (big_len > 0) begin
			push_batch(big_len);
			total = 15;
		end
		while (total < 15) begin
			int len;
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
			push_batch(len);
			total += len;
		end
		wait_drained();
	endtask

	// Driver: presents the head of the pending queue and holds it until taken.
	always @(negedge clk) begin
		if (offered_count == accepted_count) begin
			if (arst_n && pending_items.size() != 0 &&
			    $urandom_range(0, 99) >= in_idle_pct) begin
				in_valid <= 1'b1;
				value <= pending_items[0].val;
				last_item <= pending_items[0].last;
				offered_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < out_stall_pct);
	end

	// Monitor: records accepted input transactions and checks every result.
	always @(posedge clk) begin
		bit moved;
		sorted_result_t exp;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			load_and_sort(value, last_item);
			void'(pending_items.pop_front());
			accepted_count++;
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (sorted_expect.size() == 0) begin
				$display("%0t: unexpected result: value %0d last %0b overflowed %0b",
				         $time, sorted_value, last_result, overflowed);
				mismatches++;
			end else begin
				exp = sorted_expect.pop_front();
				if (sorted_value !== exp.val || last_result !== exp.last ||
				    overflowed !== exp.ovf) begin
					$display("%0t: mismatch: expected value %0d last %0b overflowed %0b",
					         $time, exp.val, exp.last, exp.ovf,
					         ", actual value %0d last %0b overflowed %0b",
					         sorted_value, last_result, overflowed);
					mismatches++;
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_order(1'b0);

		// Directed: a batch of one, then the extremes in both orders.
		push_item(32'sh7fff_ffff, 1'b1);
		push_extremes();
		wait_drained();
		write_order(1'b1);
		push_extremes();
		wait_drained();

		// The oversized batch fills the store and drops the rest, closing item included.
		run_phase(0, 0, 1'b1, 0);
		run_phase(82, 0, 1'b0, $urandom_range(65, 70));
		run_phase(0, 82, 1'b1, 0);
		run_phase(21, 21, 1'b0, 0);

		repeat (50) @(posedge clk);
		if (mismatches == 0 && sorted_expect.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/hs_pkg.sv
rtl/hs_mem.sv
rtl/hs_seq.sv
rtl/heap_sorter.sv
sim/testbench.sv
